/* rtl/core/rtch_pkg.sv */
// Shared types, constants and helpers for the ray/triangle closest-hit unit.
// No dependencies; imported by rtch core and checker files.
`default_nettype none
package rtch_pkg;

  localparam int unsigned MaxTrianglesDef = 65536;
  localparam int unsigned CoordW = 32;
  localparam int unsigned EpsW   = 16;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned DistW  = 31;
  localparam int unsigned AccW   = 50;   // dot/cross accumulator width
  localparam int unsigned CfgIdxW = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegOrgX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOrgY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOrgZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDirX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDirY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDirZ = 3'd5;
  localparam logic [CfgIdxW-1:0] RegEps  = 3'd6;

  localparam logic signed [CoordW-1:0] DirOne = 32'sh4000_0000;
  localparam logic [DistW-1:0] DistMax = 31'h7FFF_FFFF;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_CHK  = 5'b00100,
    S_DIV  = 5'b01000,
    S_UPD  = 5'b10000
  } state_e;

  // accumulator destinations
  typedef enum logic [3:0] {
    DST_NONE, DST_H0, DST_H1, DST_H2, DST_A, DST_NU,
    DST_Q0, DST_Q1, DST_Q2, DST_NV, DST_NT
  } dst_e;

  // saturate a 33-bit difference to 32 bits
  function automatic logic signed [CoordW-1:0] sat_sub(input logic signed [CoordW-1:0] x,
                                                       input logic signed [CoordW-1:0] y);
    logic signed [CoordW:0] r;
    r = {x[CoordW-1], x} - {y[CoordW-1], y};
    if (r[CoordW] != r[CoordW-1]) begin
      sat_sub = r[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      sat_sub = r[CoordW-1:0];
    end
  endfunction

  // saturate an accumulator value to 32 bits
  function automatic logic signed [CoordW-1:0] sat_acc(input logic signed [AccW-1:0] x);
    if (x > 50'sh0_0000_7FFF_FFFF) begin
      sat_acc = 32'sh7FFF_FFFF;
    end else if (x < -50'sh0_0000_8000_0000) begin
      sat_acc = 32'sh8000_0000;
    end else begin
      sat_acc = x[CoordW-1:0];
    end
  endfunction

  // clamp a direction component to +-1.0 in Q2.30
  function automatic logic signed [CoordW-1:0] sat_dir(input logic signed [CoordW-1:0] x);
    if (x > DirOne) begin
      sat_dir = DirOne;
    end else if (x < -DirOne) begin
      sat_dir = -DirOne;
    end else begin
      sat_dir = x;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ray_triangle_closest_hit_unit.sv */
// Closest-hit ray/triangle picking unit, top level.
// Depends on rtch_pkg.
`default_nettype none
// Usage:
//  - Configuration: cfg_we_i/cfg_index_i/cfg_data_i write the ray origin (Q16.16),
//    the unit direction (Q2.30, clamped to +-1.0) and epsilon while the unit is idle.
//  - Input channel (in_valid_i/in_ready_o): one triangle per item, three vertices
//    plus the final_triangle mark. in_ready_o is high only in the idle state.
//  - Output channel (out_valid_o/out_ready_i): one result per final item: hit flag,
//    stream index of the nearest hit and its distance t.
//  - Timing: 24 multiplies run on one shared 32x32 multiplier, a check state
//    follows, then the restoring divider runs when t is computed, and an update
//    state ends the item (an item past MaxTriangles skips the check). The unit
//    takes no new item until it is back in idle. A result is offered right
//    after the update cycle of its final item.
//  - If a finished result has not been taken, the update cycle of the next final
//    item waits until out_ready_i; non-final items proceed.
//  - Reset clears the running best hit and the triangle count and loads the
//    default ray (origin 0, direction +z, epsilon 1). Items past MaxTriangles are
//    not tested but a final mark still reports and clears.
module ray_triangle_closest_hit_unit
  import rtch_pkg::*;
#(
  parameter int unsigned MaxTriangles = MaxTrianglesDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [CoordW-1:0]         cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [CoordW-1:0]  a_x_i,
  input  wire logic signed [CoordW-1:0]  a_y_i,
  input  wire logic signed [CoordW-1:0]  a_z_i,
  input  wire logic signed [CoordW-1:0]  b_x_i,
  input  wire logic signed [CoordW-1:0]  b_y_i,
  input  wire logic signed [CoordW-1:0]  b_z_i,
  input  wire logic signed [CoordW-1:0]  c_x_i,
  input  wire logic signed [CoordW-1:0]  c_y_i,
  input  wire logic signed [CoordW-1:0]  c_z_i,
  input  wire logic                      final_triangle_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           hit_found_o,
  output logic [IdxW-1:0]                nearest_index_o,
  output logic [DistW-1:0]               hit_distance_o
);

  localparam int unsigned CntW = $clog2(MaxTriangles + 1);
  localparam logic [4:0] NumSteps = 5'd24;
  localparam logic [4:0] DivLast  = 5'd30;

  // configuration registers
  logic signed [CoordW-1:0] org_q [3];
  logic signed [CoordW-1:0] dir_q [3];
  logic [EpsW-1:0]          eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= DirOne;
      eps_q    <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegOrgX: org_q[0] <= cfg_data_i;
        RegOrgY: org_q[1] <= cfg_data_i;
        RegOrgZ: org_q[2] <= cfg_data_i;
        RegDirX: dir_q[0] <= cfg_data_i;
        RegDirY: dir_q[1] <= cfg_data_i;
        RegDirZ: dir_q[2] <= cfg_data_i;
        RegEps:  eps_q    <= cfg_data_i[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and item state
  state_e   state_q, state_d;
  logic [4:0] step_q;
  logic       fin_q, test_q;
  logic [IdxW-1:0] idx_q;
  logic [CntW-1:0] cnt_q;
  logic       accept;
  logic [CntW+IdxW-1:0] idx_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign idx_ext    = {{IdxW{1'b0}}, cnt_q};

  // working vectors
  logic signed [CoordW-1:0] d_q [3];
  logic signed [CoordW-1:0] e1_q [3];
  logic signed [CoordW-1:0] e2_q [3];
  logic signed [CoordW-1:0] s_q [3];
  logic signed [CoordW-1:0] h_q [3];
  logic signed [CoordW-1:0] q_q [3];
  logic signed [AccW-1:0]   a_q, nu_q, nv_q, nt_q;

  // multiply schedule: operands, shift, sign, and where the sum lands
  logic signed [CoordW-1:0] op_a, op_b;
  logic sh30, m_neg, m_first;
  dst_e m_dst;

  always_comb begin
    op_a = d_q[0];
    op_b = e2_q[0];
    sh30 = 1'b0;
    m_neg = 1'b0;
    m_first = 1'b0;
    m_dst = DST_NONE;
    case (step_q)
      // h = d x e2
      5'd0:  begin op_a = d_q[1]; op_b = e2_q[2]; sh30 = 1'b1; m_first = 1'b1; end
      5'd1:  begin op_a = d_q[2]; op_b = e2_q[1]; sh30 = 1'b1; m_neg = 1'b1; m_dst = DST_H0; end
      5'd2:  begin op_a = d_q[2]; op_b = e2_q[0]; sh30 = 1'b1; m_first = 1'b1; end
      5'd3:  begin op_a = d_q[0]; op_b = e2_q[2]; sh30 = 1'b1; m_neg = 1'b1; m_dst = DST_H1; end
      5'd4:  begin op_a = d_q[0]; op_b = e2_q[1]; sh30 = 1'b1; m_first = 1'b1; end
      5'd5:  begin op_a = d_q[1]; op_b = e2_q[0]; sh30 = 1'b1; m_neg = 1'b1; m_dst = DST_H2; end
      // a = e1 . h
      5'd6:  begin op_a = e1_q[0]; op_b = h_q[0]; m_first = 1'b1; end
      5'd7:  begin op_a = e1_q[1]; op_b = h_q[1]; end
      5'd8:  begin op_a = e1_q[2]; op_b = h_q[2]; m_dst = DST_A; end
      // nu = s . h
      5'd9:  begin op_a = s_q[0]; op_b = h_q[0]; m_first = 1'b1; end
      5'd10: begin op_a = s_q[1]; op_b = h_q[1]; end
      5'd11: begin op_a = s_q[2]; op_b = h_q[2]; m_dst = DST_NU; end
      // q = s x e1
      5'd12: begin op_a = s_q[1]; op_b = e1_q[2]; m_first = 1'b1; end
      5'd13: begin op_a = s_q[2]; op_b = e1_q[1]; m_neg = 1'b1; m_dst = DST_Q0; end
      5'd14: begin op_a = s_q[2]; op_b = e1_q[0]; m_first = 1'b1; end
      5'd15: begin op_a = s_q[0]; op_b = e1_q[2]; m_neg = 1'b1; m_dst = DST_Q1; end
      5'd16: begin op_a = s_q[0]; op_b = e1_q[1]; m_first = 1'b1; end
      5'd17: begin op_a = s_q[1]; op_b = e1_q[0]; m_neg = 1'b1; m_dst = DST_Q2; end
      // nv = d . q
      5'd18: begin op_a = d_q[0]; op_b = q_q[0]; sh30 = 1'b1; m_first = 1'b1; end
      5'd19: begin op_a = d_q[1]; op_b = q_q[1]; sh30 = 1'b1; end
      5'd20: begin op_a = d_q[2]; op_b = q_q[2]; sh30 = 1'b1; m_dst = DST_NV; end
      // nt = e2 . q
      5'd21: begin op_a = e2_q[0]; op_b = q_q[0]; m_first = 1'b1; end
      5'd22: begin op_a = e2_q[1]; op_b = q_q[1]; end
      5'd23: begin op_a = e2_q[2]; op_b = q_q[2]; m_dst = DST_NT; end
      default: ;
    endcase
  end

  // shared multiplier, floored shift, registered
  logic signed [2*CoordW-1:0] mul_full, mul_sh;
  logic signed [AccW-1:0] prod_q, acc_q, acc_sum, term;
  logic p_vld_q, p_neg_q, p_first_q;
  dst_e p_dst_q;

  assign mul_full = op_a * op_b;
  assign mul_sh   = sh30 ? (mul_full >>> 30) : (mul_full >>> 16);
  assign term     = p_neg_q ? -prod_q : prod_q;
  assign acc_sum  = (p_first_q ? '0 : acc_q) + term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= (state_q == S_MUL) && (step_q < NumSteps);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= mul_sh[AccW-1:0];
    p_neg_q   <= m_neg;
    p_first_q <= m_first;
    p_dst_q   <= m_dst;
  end

  // check stage: sign fold and range tests
  logic signed [AccW-1:0] a_abs, nu_n, nv_n, nt_n;
  logic signed [AccW:0]   uv_sum;
  logic rej_par, rej_uv, nt_big;

  assign a_abs   = a_q[AccW-1] ? -a_q : a_q;
  assign nu_n    = a_q[AccW-1] ? -nu_q : nu_q;
  assign nv_n    = a_q[AccW-1] ? -nv_q : nv_q;
  assign nt_n    = a_q[AccW-1] ? -nt_q : nt_q;
  assign uv_sum  = {nu_n[AccW-1], nu_n} + {nv_n[AccW-1], nv_n};
  assign rej_par = (a_q == '0) || (a_abs < $signed({{(AccW-EpsW){1'b0}}, eps_q}));
  assign rej_uv  = nu_n[AccW-1] || (nu_n > a_abs) || nv_n[AccW-1] ||
                   (uv_sum > {a_abs[AccW-1], a_abs});
  assign nt_big  = {15'b0, nt_n} >= {a_abs, 15'b0};

  // restoring divider, one quotient bit per cycle
  logic [AccW:0]   rem_q, rem_sh;
  logic [DistW-1:0] div_w_q;
  logic            qbit;
  logic [AccW:0]   a_ext;

  assign a_ext  = {1'b0, a_q};
  assign rem_sh = {rem_q[AccW-1:0], div_w_q[DistW-1]};
  assign qbit   = rem_sh >= a_ext;

  // result of the current triangle and running best
  logic            hit_q;
  logic [DistW-1:0] t_q;
  logic [DistW-1:0] best_q;
  logic [IdxW-1:0]  best_idx_q;
  logic             any_q;
  logic             upd_go, better, out_load;

  assign upd_go   = !(fin_q && out_valid_o && !out_ready_i);
  assign better   = test_q && hit_q && (t_q > {{(DistW-EpsW){1'b0}}, eps_q}) && (t_q < best_q);
  assign out_load = (state_q == S_UPD) && upd_go && fin_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_MUL;
      S_MUL:  if (step_q == NumSteps) state_d = test_q ? S_CHK : S_UPD;
      S_CHK: begin
        if (rej_par || rej_uv || !nt_n[AccW-1] && nt_n != '0 && !nt_big) begin
          state_d = (rej_par || rej_uv) ? S_UPD : S_DIV;
        end else begin
          state_d = S_UPD;
        end
      end
      S_DIV:  if (step_q == DivLast) state_d = S_UPD;
      S_UPD:  if (upd_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      best_q      <= DistMax;
      best_idx_q  <= '0;
      any_q       <= 1'b0;
      out_valid_o <= 1'b0;
      fin_q       <= 1'b0;
      test_q      <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new result replaces one taken in the same cycle
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          step_q <= '0;
          hit_q  <= 1'b0;
          if (accept) begin
            fin_q  <= final_triangle_i;
            test_q <= (cnt_q < CntW'(MaxTriangles));
            if (cnt_q < CntW'(MaxTriangles)) cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MUL: step_q <= step_q + 1'b1;
        S_CHK: begin
          step_q <= '0;
          hit_q  <= !(rej_par || rej_uv);
        end
        S_DIV: step_q <= step_q + 1'b1;
        S_UPD: begin
          if (upd_go) begin
            if (fin_q) begin
              cnt_q       <= '0;
              best_q      <= DistMax;
              best_idx_q  <= '0;
              any_q       <= 1'b0;
            end else if (better) begin
              best_q     <= t_q;
              best_idx_q <= idx_q;
              any_q      <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q    <= idx_ext[IdxW-1:0];
      d_q[0]   <= sat_dir(dir_q[0]);
      d_q[1]   <= sat_dir(dir_q[1]);
      d_q[2]   <= sat_dir(dir_q[2]);
      e1_q[0]  <= sat_sub(b_x_i, a_x_i);
      e1_q[1]  <= sat_sub(b_y_i, a_y_i);
      e1_q[2]  <= sat_sub(b_z_i, a_z_i);
      e2_q[0]  <= sat_sub(c_x_i, a_x_i);
      e2_q[1]  <= sat_sub(c_y_i, a_y_i);
      e2_q[2]  <= sat_sub(c_z_i, a_z_i);
      s_q[0]   <= sat_sub(org_q[0], a_x_i);
      s_q[1]   <= sat_sub(org_q[1], a_y_i);
      s_q[2]   <= sat_sub(org_q[2], a_z_i);
    end
    // accumulate and write back
    if (p_vld_q) begin
      acc_q <= acc_sum;
      case (p_dst_q)
        DST_H0: h_q[0] <= sat_acc(acc_sum);
        DST_H1: h_q[1] <= sat_acc(acc_sum);
        DST_H2: h_q[2] <= sat_acc(acc_sum);
        DST_Q0: q_q[0] <= sat_acc(acc_sum);
        DST_Q1: q_q[1] <= sat_acc(acc_sum);
        DST_Q2: q_q[2] <= sat_acc(acc_sum);
        DST_A:  a_q    <= acc_sum;
        DST_NU: nu_q   <= acc_sum;
        DST_NV: nv_q   <= acc_sum;
        DST_NT: nt_q   <= acc_sum;
        default: ;
      endcase
    end
    // fold sign, pick t or start the divider
    if (state_q == S_CHK) begin
      a_q     <= a_abs;
      rem_q   <= {16'b0, nt_n[AccW-1:15]};
      div_w_q <= {nt_n[14:0], 16'b0};
      if (nt_n[AccW-1] || nt_n == '0) begin
        t_q <= '0;
      end else begin
        t_q <= DistMax;
      end
    end
    if (state_q == S_DIV) begin
      rem_q   <= qbit ? (rem_sh - a_ext) : rem_sh;
      div_w_q <= {div_w_q[DistW-2:0], qbit};
      if (step_q == DivLast) t_q <= {div_w_q[DistW-2:0], qbit};
    end
    // result item
    if (out_load) begin
      hit_found_o     <= any_q || better;
      nearest_index_o <= better ? idx_q : best_idx_q;
      hit_distance_o  <= better ? t_q : ((any_q) ? best_q : '0);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rtch_checker.sv */
// Port-level checks for the closest-hit unit, bound to the top level.
// Depends on rtch_pkg and ray_triangle_closest_hit_unit.
`default_nettype none
module rtch_checker
  import rtch_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic             hit_found_o,
  input wire logic [IdxW-1:0]  nearest_index_o,
  input wire logic [DistW-1:0] hit_distance_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // the unit is busy right after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // a miss reports zero index and distance
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_found_o |-> nearest_index_o == '0 && hit_distance_o == '0)
    else $error("miss with nonzero payload");

  // a hit lies beyond epsilon, so its distance is never zero
  a_hit_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_found_o |-> hit_distance_o != '0)
    else $error("hit with zero distance");

endmodule

bind ray_triangle_closest_hit_unit rtch_checker u_rtch_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .hit_found_o(hit_found_o),
  .nearest_index_o(nearest_index_o),
  .hit_distance_o(hit_distance_o)
);
`default_nettype wire
